// File: sv/lsbbp_pkg.sv
// Package for the LSB-first bit packer: item structs, request and status codes,
// and the sequencer state type. No dependencies.
package lsbbp_pkg;

    localparam int FILL_W = 13;   // width of the fill count carried in a result item

    typedef enum logic {
        REQ_APPEND  = 1'b0,
        REQ_EXTRACT = 1'b1
    } req_kind_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OFFSET   = 2'd1;
    localparam logic [1:0] STATUS_PAST_END = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP1,
        S_OP2,
        S_OP3,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  append_byte;
        logic [2:0]  source_offset;
        logic [3:0]  field_width;
        logic [11:0] read_position;
        logic [7:0]  merge_byte;
        logic [2:0]  target_offset;
    } req_item_t;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill_bits;
    } rsp_item_t;

endpackage

// File: sv/lsbbp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lsbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: sv/lsb_first_bit_packer.sv
// Top level of the LSB-first bit packer: sequencer, fill tracking and byte merge.
// Depends on lsbbp_pkg and lsbbp_ram.
//
// Bit buffer that keeps a stream of bits least significant first in a byte
// store of BUFFER_BYTES bytes (stream bit n sits in byte n/8 at bit n%8). An
// append item places field_width bits of append_byte, taken from source_offset,
// right after the stored bits; an extract item reads field_width stored bits
// from read_position and merges them into merge_byte at target_offset. Every
// item gives exactly one result item with a status and the fill after the
// item. Errors (offset plus width over 8, read beyond fill, store full) change
// nothing and return merge_byte unchanged. The store is one single-port RAM
// with registered read and each store byte touched is its own step: an append
// writes the tail byte, then the spill byte if the field spans two bytes; an
// extract reads the first byte, then its neighbor only if the field crosses
// into it, then merges. Errors and zero-width items touch no byte. The next
// item is taken the cycle after the result is loaded into the output register;
// a result waiting on rsp_stall holds the sequencer in its final state. The
// partly filled last byte is kept in a register, so appends never read the RAM.
// No clearing pass is needed after reset: bytes are read only below the fill.
module lsb_first_bit_packer #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  lsbbp_pkg::req_item_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output lsbbp_pkg::rsp_item_t rsp
);

    import lsbbp_pkg::*;

    localparam int CAP_BITS = BUFFER_BYTES * 8;
    localparam int AW       = $clog2(BUFFER_BYTES);
    localparam int SW       = $clog2(CAP_BITS + 1);
    localparam int CW       = ((SW > 12) ? SW : 12) + 1;
    localparam logic [SW:0] CAP_W = (SW + 1)'(CAP_BITS);

    seq_state_t       state_reg, state_next;
    req_item_t        item_reg, item_next;
    logic [SW-1:0]    stored_bits_reg, stored_bits_next;
    logic [7:0]       tail_reg, tail_next;
    logic [7:0]       byte0_reg, byte0_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [7:0]       res_byte_reg, res_byte_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_item_t        rsp_reg, rsp_next;

    // RAM port
    logic             mem_en;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;

    // Datapath terms
    logic [3:0]       w;
    logic [8:0]       mask9;
    logic [7:0]       mask;
    logic [CW-1:0]    stored_ext;
    logic [CW-1:0]    rpos_ext;
    logic [CW-1:0]    read_end;
    logic [SW:0]      fill_sum;
    logic [4:0]       src_end;
    logic [4:0]       dst_end;
    logic [4:0]       tail_end;
    logic [4:0]       rd_end;
    logic [2:0]       fill_off;
    logic [7:0]       src_bits;
    logic [15:0]      comb16;
    logic [AW-1:0]    fill_idx;
    logic [AW-1:0]    rpos_idx;
    logic [15:0]      pair16;
    logic [7:0]       field8;
    logic [15:0]      keep16;
    logic [15:0]      ins16;
    logic             can_load;

    lsbbp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Field mask: widths 9 and above only occur on error paths.
    assign w      = item_reg.field_width;
    assign mask9  = (9'd1 << w) - 9'd1;
    assign mask   = mask9[7:0];

    assign stored_ext = CW'(stored_bits_reg);
    assign rpos_ext   = CW'(item_reg.read_position);
    assign read_end   = rpos_ext + CW'(w);
    assign fill_sum   = {1'b0, stored_bits_reg} + (SW + 1)'(w);
    assign src_end    = {2'b00, item_reg.source_offset} + {1'b0, w};
    assign dst_end    = {2'b00, item_reg.target_offset} + {1'b0, w};
    assign rd_end     = {2'b00, item_reg.read_position[2:0]} + {1'b0, w};

    // Append: merge the new field above the partial tail byte.
    assign fill_off   = stored_bits_reg[2:0];
    assign tail_end   = {2'b00, fill_off} + {1'b0, w};
    assign src_bits   = (item_reg.append_byte >> item_reg.source_offset) & mask;
    assign comb16     = {8'h00, tail_reg} | ({8'h00, src_bits} << fill_off);
    assign fill_idx   = stored_bits_reg[AW+2:3];
    assign rpos_idx   = rpos_ext[AW+2:3];

    // Extract: second byte is masked off when the field stays in one byte.
    assign pair16     = {mem_rdata, byte0_reg} >> item_reg.read_position[2:0];
    assign field8     = pair16[7:0] & mask;
    assign keep16     = {8'h00, mask} << item_reg.target_offset;
    assign ins16      = {8'h00, field8} << item_reg.target_offset;

    assign can_load   = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stored_bits_reg <= '0;
            tail_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stored_bits_reg <= stored_bits_next;
            tail_reg        <= tail_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        byte0_reg      <= byte0_next;
        addr_reg       <= addr_next;
        res_byte_reg   <= res_byte_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        stored_bits_next = stored_bits_reg;
        tail_next        = tail_reg;
        byte0_next       = byte0_reg;
        addr_next        = addr_reg;
        res_byte_next    = res_byte_reg;
        res_status_next  = res_status_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        req_stall        = 1'b1;
        mem_en           = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = fill_idx;
        mem_wdata        = comb16[7:0];

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_OP1;
                end
            end

            S_OP1:
            begin
                // Check, then launch the first store access.
                res_byte_next   = item_reg.merge_byte;
                res_status_next = STATUS_OK;
                state_next      = S_DONE;
                if (item_reg.req_type == REQ_APPEND)
                begin
                    priority if (src_end > 5'd8)
                    begin
                        res_status_next = STATUS_OFFSET;
                    end
                    else if (fill_sum > CAP_W)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    else if (w != 4'd0)
                    begin
                        mem_en           = 1'b1;
                        mem_we           = 1'b1;
                        mem_addr         = fill_idx;
                        mem_wdata        = comb16[7:0];
                        byte0_next       = comb16[15:8];
                        addr_next        = fill_idx + AW'(1);
                        stored_bits_next = fill_sum[SW-1:0];
                        tail_next        = (tail_end >= 5'd8) ? comb16[15:8] : comb16[7:0];
                        if (tail_end > 5'd8)
                        begin
                            state_next = S_OP2;
                        end
                    end
                end
                else
                begin
                    priority if (dst_end > 5'd8)
                    begin
                        res_status_next = STATUS_OFFSET;
                    end
                    else if (read_end > stored_ext)
                    begin
                        res_status_next = STATUS_PAST_END;
                    end
                    else if (w != 4'd0)
                    begin
                        mem_en     = 1'b1;
                        mem_addr   = rpos_idx;
                        addr_next  = rpos_idx + AW'(1);
                        state_next = S_OP2;
                    end
                end
            end

            S_OP2:
            begin
                mem_addr = addr_reg;
                if (item_reg.req_type == REQ_APPEND)
                begin
                    // Spill the upper part of the field into the next byte.
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = byte0_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    // Hold the first byte; fetch its neighbor only when the
                    // field crosses into it, else the read data stays put.
                    mem_en     = (rd_end > 5'd8);
                    byte0_next = mem_rdata;
                    state_next = S_OP3;
                end
            end

            S_OP3:
            begin
                res_byte_next = (item_reg.merge_byte & ~keep16[7:0]) | ins16[7:0];
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (can_load)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.read_byte = res_byte_reg;
                    rsp_next.status    = res_status_reg;
                    rsp_next.fill_bits = stored_ext[FILL_W-1:0];
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The fill never passes the store capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, stored_bits_reg} <= CAP_W)
        else $error("fill count beyond capacity");

    // Bits of the tail register above the fill offset stay clear.
    a_tail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg >> fill_off) == 8'h00)
        else $error("tail byte holds bits above the fill");

    // The fill moves only as an append is checked.
    a_fill_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stored_bits_reg) |-> $past(state_reg) == S_OP1)
        else $error("fill changed outside the append step");

    // Leaving the final state always presents a result.
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> rsp_valid)
        else $error("finished item without a result");

    // No new item while the sequencer is busy.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> req_stall)
        else $error("item taken while busy");

endmodule
